// File: hdl/kbcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbcs_pkg
// Types, codes and helpers shared by the keyed best candidate selector.
// ----------------------------------------------------------------------------
package kbcs_pkg;

    // Table size; a power of two so that the probe address wraps by itself.
    localparam int TABLE_ENTRIES = 1024;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int KEY_W         = 34;

    // Operation codes.
    localparam logic [1:0] OP_OFFER    = 2'd0;
    localparam logic [1:0] OP_QUERY    = 2'd1;
    localparam logic [1:0] OP_FILTERED = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    // Verdict codes.
    localparam logic [2:0] VERDICT_TAKEN    = 3'd0;
    localparam logic [2:0] VERDICT_KEEP     = 3'd1;
    localparam logic [2:0] VERDICT_REJECT   = 3'd2;
    localparam logic [2:0] VERDICT_FILTERED = 3'd3;
    localparam logic [2:0] VERDICT_FULL     = 3'd4;

    localparam logic [15:0] KEPT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] item_id;
        logic [15:0] gene_first;
        logic [15:0] gene_second;
        logic        dir_first;
        logic        dir_second;
        logic [15:0] split_count_first;
        logic [15:0] split_count_second;
        logic [15:0] mate_count;
        logic [17:0] support_total;
        logic [31:0] position_first;
        logic [31:0] position_second;
    } request_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [15:0] kept_count;
    } result_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [15:0]      item;
        logic [1:0]       rank;
        logic [17:0]      support;
        logic [31:0]      position_first;
        logic [31:0]      position_second;
    } entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } state_t;

    // Folds the key onto the table address by XOR of its bits.
    function automatic logic [ADDR_W-1:0] key_hash(input logic [KEY_W-1:0] key);
        logic [ADDR_W-1:0] h;
        h = '0;
        for (int i = 0; i < KEY_W; i++)
        begin
            h[i % ADDR_W] = h[i % ADDR_W] ^ key[i];
        end
        return h;
    endfunction

    // Rank from the split and mate counts.
    function automatic logic [1:0] calc_rank(input logic [15:0] s1,
                                             input logic [15:0] s2,
                                             input logic [15:0] m);
        logic a;
        logic b;
        logic c;
        a = (s1 != '0);
        b = (s2 != '0);
        c = (m != '0);
        if (a && b)
            return 2'd3;
        else if ((a || b) && c)
            return 2'd2;
        else if (a || b)
            return 2'd1;
        else
            return 2'd0;
    endfunction

endpackage

// File: hdl/keyed_best_candidate_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_best_candidate_selector
// Hashed table with linear probing that keeps the best candidate per key.
// ----------------------------------------------------------------------------
// Filtered and clear items give their result in the cycle after acceptance.
// Offers and queries probe the table from the home slot of the key, each probe
// a registered read (ST_READ) and a check (ST_CHECK), up to all TABLE_ENTRIES
// slots; the result is registered after the last check. After reset and after
// each clear item the whole table is swept, entry by entry, with busy high.
// The receiver cannot stall; results last one cycle.
module keyed_best_candidate_selector (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  kbcs_pkg::request_t  request,
    output logic                strobe,
    output kbcs_pkg::result_t   result
);

    kbcs_pkg::entry_t mem [kbcs_pkg::TABLE_ENTRIES];
    kbcs_pkg::entry_t rd_data_reg;

    kbcs_pkg::state_t state_reg, state_next;
    kbcs_pkg::request_t req_reg, req_next;
    logic [kbcs_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [kbcs_pkg::ADDR_W-1:0] probe_reg, probe_next;
    logic [15:0] kept_reg, kept_next;
    logic strobe_reg, strobe_next;
    kbcs_pkg::result_t result_reg, result_next;

    logic                        wr_en;
    logic [kbcs_pkg::ADDR_W-1:0] wr_addr;
    kbcs_pkg::entry_t            wr_data;

    logic [kbcs_pkg::KEY_W-1:0] req_key;
    logic [kbcs_pkg::KEY_W-1:0] start_key;
    logic [1:0] req_rank;
    logic       take;
    kbcs_pkg::entry_t new_entry;

    assign busy   = (state_reg != kbcs_pkg::ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // Key and candidate entry of the held item.
    assign req_key   = {req_reg.gene_first, req_reg.gene_second,
                        req_reg.dir_first, req_reg.dir_second};
    assign start_key = {request.gene_first, request.gene_second,
                        request.dir_first, request.dir_second};
    assign req_rank  = kbcs_pkg::calc_rank(req_reg.split_count_first,
                                           req_reg.split_count_second,
                                           req_reg.mate_count);

    always_comb
    begin
        new_entry.valid           = 1'b1;
        new_entry.key             = req_key;
        new_entry.item            = req_reg.item_id;
        new_entry.rank            = req_rank;
        new_entry.support         = req_reg.support_total;
        new_entry.position_first  = req_reg.position_first;
        new_entry.position_second = req_reg.position_second;
    end

    // Ordering of the offer against the stored best.
    always_comb
    begin
        take = 1'b0;
        if (req_rank > rd_data_reg.rank)
            take = 1'b1;
        else if (req_rank == rd_data_reg.rank)
        begin
            if (req_reg.support_total > rd_data_reg.support)
                take = 1'b1;
            else if (req_reg.support_total == rd_data_reg.support)
            begin
                if (req_reg.dir_first ?
                        (req_reg.position_first > rd_data_reg.position_first) :
                        (req_reg.position_first < rd_data_reg.position_first))
                    take = 1'b1;
                else if (req_reg.position_first == rd_data_reg.position_first &&
                         (req_reg.dir_second ?
                          (req_reg.position_second > rd_data_reg.position_second) :
                          (req_reg.position_second < rd_data_reg.position_second)))
                    take = 1'b1;
            end
        end
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[addr_reg];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= kbcs_pkg::ST_CLEAR;
            addr_reg   <= '0;
            probe_reg  <= '0;
            kept_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            probe_reg  <= probe_next;
            kept_reg   <= kept_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    // Next state, table access and results.
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        addr_next   = addr_reg;
        probe_next  = probe_reg;
        kept_next   = kept_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        wr_en       = 1'b0;
        wr_addr     = addr_reg;
        wr_data     = new_entry;

        case (state_reg)
            kbcs_pkg::ST_CLEAR:
            begin
                // Sweep one entry a cycle, marking it free.
                wr_en         = 1'b1;
                wr_data       = '0;
                addr_next     = addr_reg + 1'b1;
                if (addr_reg == {kbcs_pkg::ADDR_W{1'b1}})
                    state_next = kbcs_pkg::ST_IDLE;
            end
            kbcs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    case (request.opcode)
                        kbcs_pkg::OP_FILTERED:
                        begin
                            strobe_next = 1'b1;
                            result_next.verdict    = kbcs_pkg::VERDICT_FILTERED;
                            result_next.kept_count = kept_reg;
                        end
                        kbcs_pkg::OP_CLEAR:
                        begin
                            kept_next   = '0;
                            strobe_next = 1'b1;
                            result_next.verdict    = kbcs_pkg::VERDICT_TAKEN;
                            result_next.kept_count = '0;
                            addr_next   = '0;
                            state_next  = kbcs_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            addr_next  = kbcs_pkg::key_hash(start_key);
                            probe_next = '0;
                            state_next = kbcs_pkg::ST_READ;
                        end
                    endcase
                end
            end
            kbcs_pkg::ST_READ:
            begin
                // Read of addr_reg is in flight.
                state_next = kbcs_pkg::ST_CHECK;
            end
            kbcs_pkg::ST_CHECK:
            begin
                if (rd_data_reg.valid && rd_data_reg.key == req_key)
                begin
                    // Key found.
                    strobe_next = 1'b1;
                    state_next  = kbcs_pkg::ST_IDLE;
                    if (req_reg.opcode == kbcs_pkg::OP_OFFER)
                    begin
                        wr_en = take;
                        result_next.verdict = kbcs_pkg::VERDICT_TAKEN;
                        result_next.kept_count = kept_reg;
                    end
                    else if (rd_data_reg.item == req_reg.item_id)
                    begin
                        if (kept_reg != kbcs_pkg::KEPT_MAX)
                            kept_next = kept_reg + 1'b1;
                        result_next.verdict = kbcs_pkg::VERDICT_KEEP;
                        result_next.kept_count = (kept_reg != kbcs_pkg::KEPT_MAX) ?
                                                 kept_reg + 1'b1 : kept_reg;
                    end
                    else
                    begin
                        result_next.verdict = kbcs_pkg::VERDICT_REJECT;
                        result_next.kept_count = kept_reg;
                    end
                end
                else if (!rd_data_reg.valid)
                begin
                    // Free slot ends the probe: the key is absent.
                    strobe_next = 1'b1;
                    state_next  = kbcs_pkg::ST_IDLE;
                    result_next.kept_count = kept_reg;
                    if (req_reg.opcode == kbcs_pkg::OP_OFFER)
                    begin
                        wr_en = 1'b1;
                        result_next.verdict = kbcs_pkg::VERDICT_TAKEN;
                    end
                    else
                        result_next.verdict = kbcs_pkg::VERDICT_REJECT;
                end
                else if (probe_reg == {kbcs_pkg::ADDR_W{1'b1}})
                begin
                    // Every slot probed and all taken by other keys.
                    strobe_next = 1'b1;
                    state_next  = kbcs_pkg::ST_IDLE;
                    result_next.kept_count = kept_reg;
                    result_next.verdict = (req_reg.opcode == kbcs_pkg::OP_OFFER) ?
                                          kbcs_pkg::VERDICT_FULL :
                                          kbcs_pkg::VERDICT_REJECT;
                end
                else
                begin
                    // Linear probe to the next slot.
                    addr_next  = addr_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    state_next = kbcs_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = kbcs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/kbcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbcs_checker
// Port-level assertions for the keyed best candidate selector.
// ----------------------------------------------------------------------------
module kbcs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input kbcs_pkg::request_t request,
    input logic               strobe,
    input kbcs_pkg::result_t  result
);

    // A filtered item is answered in the next cycle with its verdict.
    a_filtered: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.opcode == kbcs_pkg::OP_FILTERED) |=>
        (strobe && result.verdict == kbcs_pkg::VERDICT_FILTERED))
        else $error("filtered item not answered");

    // A clear item zeroes the count and keeps the block busy for the sweep.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.opcode == kbcs_pkg::OP_CLEAR) |=>
        (strobe && result.kept_count == '0 && busy))
        else $error("clear item mishandled");

    // Verdicts stay within their codes.
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.verdict <= kbcs_pkg::VERDICT_FULL))
        else $error("verdict out of range");

    // An offer or query never answers in the cycle right after acceptance.
    a_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.opcode == kbcs_pkg::OP_OFFER ||
                            request.opcode == kbcs_pkg::OP_QUERY)) |=> !strobe)
        else $error("lookup answered too early");

endmodule

bind keyed_best_candidate_selector kbcs_checker u_kbcs_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result)
);
